// ----- rtl/core/pwbs_pkg.sv -----
// Shared types, widths and constants for the pulse width bit serializer.
package pwbs_pkg;

  localparam int BYTE_W = 8;
  localparam int TICK_W = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int DEF_BITS_PER_BYTE = 8;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  localparam logic [TICK_W-1:0] RST_HIGH_ZERO = 16'd35;
  localparam logic [TICK_W-1:0] RST_PERIOD_ZERO = 16'd125;
  localparam logic [TICK_W-1:0] RST_HIGH_ONE = 16'd70;
  localparam logic [TICK_W-1:0] RST_PERIOD_ONE = 16'd125;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HIGH_ZERO = 8'd0,
    REG_PERIOD_ZERO = 8'd1,
    REG_HIGH_ONE = 8'd2,
    REG_PERIOD_ONE = 8'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } command_t;

  typedef struct packed {
    logic [TICK_W-1:0] high_zero;
    logic [TICK_W-1:0] period_zero;
    logic [TICK_W-1:0] high_one;
    logic [TICK_W-1:0] period_one;
  } timing_t;

  typedef struct packed {
    logic [BYTE_W-1:0] shift_byte;
    logic [BYTE_W-1:0] pending_byte;
    logic              pending_valid;
    logic [TICK_W-1:0] tick_count;
    logic              sending;
  } serial_state_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic load_accepted;
    logic byte_done;
  } result_t;

endpackage

// ----- rtl/core/pwbs_item_if.sv -----
// Input item channel: command and byte to send.
interface pwbs_item_if;
  import pwbs_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

// ----- rtl/core/pwbs_result_if.sv -----
// Result item channel: pin level and status flags.
interface pwbs_result_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic load_accepted;
  logic byte_done;

  modport source (output valid, pin_level, busy_res, load_accepted, byte_done, input ready);
  modport sink (input valid, pin_level, busy_res, load_accepted, byte_done, output ready);
endinterface

// ----- rtl/core/pwbs_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface pwbs_cfg_if;
  import pwbs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [TICK_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/pwbs_step.sv -----
// Next-state and result logic for one item of the serializer.
module pwbs_step
  import pwbs_pkg::*;
#(
  parameter int BITS_PER_BYTE = DEF_BITS_PER_BYTE,
  parameter int POS_W = 3
) (
  input  timing_t           timing,
  input  serial_state_t     cur,
  input  logic [POS_W-1:0]  bit_position,
  input  logic              command,
  input  logic [BYTE_W-1:0] data_byte,
  output serial_state_t     nxt,
  output logic [POS_W-1:0]  bit_position_next,
  output result_t           res
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BITS_PER_BYTE - 1);

  logic [TICK_W-1:0] cur_high;
  logic [TICK_W-1:0] cur_period;
  logic [TICK_W-1:0] cur_len;
  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] next_high;
  logic              accepted;
  logic              done;

  always_comb begin
    cur_high = cur.shift_byte[BYTE_W-1] ? timing.high_one : timing.high_zero;
    cur_period = cur.shift_byte[BYTE_W-1] ? timing.period_one : timing.period_zero;
    cur_len = (cur_period > cur_high) ? cur_period : cur_high;
    if (cur_len == '0) begin
      cur_len = TICK_W'(1);
    end
    tick_inc = (cur.tick_count != TICK_MAX) ? cur.tick_count + TICK_W'(1) : cur.tick_count;

    nxt = cur;
    bit_position_next = bit_position;
    accepted = 1'b0;
    done = 1'b0;

    if (command == CMD_LOAD) begin
      if (!cur.sending) begin
        nxt.shift_byte = data_byte;
        nxt.tick_count = '0;
        nxt.sending = 1'b1;
        bit_position_next = '0;
        accepted = 1'b1;
      end else if (!cur.pending_valid) begin
        nxt.pending_byte = data_byte;
        nxt.pending_valid = 1'b1;
        accepted = 1'b1;
      end
    end else if (cur.sending) begin
      nxt.tick_count = tick_inc;
      if (tick_inc >= cur_len) begin
        nxt.tick_count = '0;
        if (bit_position >= LAST_POS) begin
          done = 1'b1;
          bit_position_next = '0;
          if (cur.pending_valid) begin
            nxt.pending_valid = 1'b0;
            nxt.shift_byte = cur.pending_byte;
          end else begin
            nxt.sending = 1'b0;
          end
        end else begin
          nxt.shift_byte = {cur.shift_byte[BYTE_W-2:0], 1'b0};
          bit_position_next = bit_position + POS_W'(1);
        end
      end
    end

    // pin follows the state after the update, against the new bit's high time
    next_high = nxt.shift_byte[BYTE_W-1] ? timing.high_one : timing.high_zero;
    res.pin_level = nxt.sending && (nxt.tick_count < next_high);
    res.busy_res = nxt.sending;
    res.load_accepted = accepted;
    res.byte_done = done;
  end

endmodule

// ----- rtl/core/pulse_width_bit_serializer_core.sv -----
// Top level of the pulse width bit serializer: state, config registers, result register.
//
//   channel | role   | payload
//   --------+--------+---------------------------------------------------
//   item    | sink   | command (tick / load), data_byte[7:0]
//   result  | source | pin_level, busy_res, load_accepted, byte_done
//   cfg     | sink   | index[7:0], data[15:0]; always ready
//
// One item per cycle while no held result stalls the input: each transfer updates
// the state in one pass and its result lands in the result register on the same edge.
// item.ready is high while the result register is empty or being drained;
// a result held by result.ready low blocks the input in that same cycle.
// rst is synchronous; it clears all control state and restores the
// timing registers to their defaults (35 / 125 / 70 / 125 ticks).
module pulse_width_bit_serializer_core
  import pwbs_pkg::*;
#(
  parameter int BITS_PER_BYTE = DEF_BITS_PER_BYTE
) (
  input logic           clk,
  input logic           rst,
  pwbs_item_if.sink     item,
  pwbs_result_if.source result,
  pwbs_cfg_if.sink      cfg
);

  localparam int POS_W = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;

  timing_t          timing;
  serial_state_t    state;
  serial_state_t    state_next;
  logic [POS_W-1:0] bit_position;
  logic [POS_W-1:0] bit_position_next;
  result_t          res_next;
  result_t          res;
  logic             out_valid;
  logic             item_xfer;

  assign item.ready = !out_valid || result.ready;
  assign item_xfer = item.valid && item.ready;
  assign cfg.ready = 1'b1;

  pwbs_step #(
    .BITS_PER_BYTE(BITS_PER_BYTE),
    .POS_W(POS_W)
  ) u_step (
    .timing(timing),
    .cur(state),
    .bit_position(bit_position),
    .command(item.command),
    .data_byte(item.data_byte),
    .nxt(state_next),
    .bit_position_next(bit_position_next),
    .res(res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.high_zero <= RST_HIGH_ZERO;
      timing.period_zero <= RST_PERIOD_ZERO;
      timing.high_one <= RST_HIGH_ONE;
      timing.period_one <= RST_PERIOD_ONE;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HIGH_ZERO: timing.high_zero <= cfg.data;
        REG_PERIOD_ZERO: timing.period_zero <= cfg.data;
        REG_HIGH_ONE: timing.high_one <= cfg.data;
        REG_PERIOD_ONE: timing.period_one <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      bit_position <= '0;
    end else if (item_xfer) begin
      state <= state_next;
      bit_position <= bit_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_xfer) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      res <= res_next;
    end
  end

  assign result.valid = out_valid;
  assign result.pin_level = res.pin_level;
  assign result.busy_res = res.busy_res;
  assign result.load_accepted = res.load_accepted;
  assign result.byte_done = res.byte_done;

`ifndef SYNTHESIS
  a_pending_needs_sending: assert property (@(posedge clk) disable iff (rst)
    state.pending_valid |-> state.sending)
    else $error("holding register full while idle");

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (rst)
    !state.sending |-> (state.tick_count == '0 && bit_position == '0))
    else $error("bit counters not cleared while idle");

  a_refused_load: assert property (@(posedge clk) disable iff (rst)
    (item_xfer && item.command == CMD_LOAD && state.sending && state.pending_valid)
    |=> !res.load_accepted)
    else $error("load accepted with holding register full");

  a_accept_means_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.load_accepted) |-> res.busy_res)
    else $error("load accepted but not sending");
`endif

endmodule

// ----- test/testbench.sv -----
// Testbench for the pulse width bit serializer: directed and random stimulus, scoreboard check.
`timescale 1ns / 1ps

module testbench;
  import pwbs_pkg::*;

  localparam int BITS = DEF_BITS_PER_BYTE;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 2;

  // Tracks the serializer state and holds the results it should produce, oldest first.
  class pulse_checker;
    timing_t     timing;
    logic [7:0]  shift_q;
    logic [7:0]  hold_q;
    bit          hold_full;
    int unsigned bit_idx;
    logic [15:0] ticks;
    bit          busy;
    result_t     due_results[$];
    int          errors;
    int          n_items;
    int          n_taken;
    int          n_refused;
    int          n_bytes;
    int          n_writes;

    function new();
      timing = '{RST_HIGH_ZERO, RST_PERIOD_ZERO, RST_HIGH_ONE, RST_PERIOD_ONE};
      shift_q = '0;
      hold_q = '0;
      hold_full = 0;
      bit_idx = 0;
      ticks = '0;
      busy = 0;
      errors = 0;
      n_items = 0;
      n_taken = 0;
      n_refused = 0;
      n_bytes = 0;
      n_writes = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void write_timing(logic [CFG_INDEX_W-1:0] idx, logic [TICK_W-1:0] val);
      n_writes++;
      case (idx)
        REG_HIGH_ZERO:   timing.high_zero = val;
        REG_PERIOD_ZERO: timing.period_zero = val;
        REG_HIGH_ONE:    timing.high_one = val;
        REG_PERIOD_ONE:  timing.period_one = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] bit_high();
      return shift_q[7] ? timing.high_one : timing.high_zero;
    endfunction

    // Bit lasts max(period, high), and never less than one tick.
    function int unsigned bit_len();
      int unsigned hi;
      int unsigned per;
      hi = 32'(bit_high());
      per = 32'(shift_q[7] ? timing.period_one : timing.period_zero);
      if (hi > per) per = hi;
      return (per == 0) ? 1 : per;
    endfunction

    function void start_byte(logic [7:0] d);
      shift_q = d;
      bit_idx = 0;
      ticks = '0;
      busy = 1;
    endfunction

    function void take_item(command_t cmd, logic [7:0] d);
      result_t r;
      bit taken;
      bit done;
      taken = 0;
      done = 0;
      n_items++;
      if (cmd == CMD_LOAD) begin
        if (!busy) begin
          start_byte(d);
          taken = 1;
        end else if (!hold_full) begin
          hold_q = d;
          hold_full = 1;
          taken = 1;
        end
        if (taken) n_taken++;
        else n_refused++;
      end else if (busy) begin
        if (ticks != TICK_MAX) ticks++;
        if (ticks >= bit_len()) begin
          if (bit_idx >= BITS - 1) begin
            done = 1;
            n_bytes++;
            if (hold_full) begin
              hold_full = 0;
              start_byte(hold_q);
            end else begin
              busy = 0;
              ticks = '0;
              bit_idx = 0;
            end
          end else begin
            shift_q = shift_q << 1;
            bit_idx++;
            ticks = '0;
          end
        end
      end
      r.pin_level = busy && (ticks < bit_high());
      r.busy_res = busy;
      r.load_accepted = taken;
      r.byte_done = done;
      due_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with nothing outstanding: pin %0b busy %0b taken %0b done %0b",
                   got.pin_level, got.busy_res, got.load_accepted, got.byte_done);
        return;
      end
      want = due_results.pop_front();
      if (got.pin_level !== want.pin_level || got.busy_res !== want.busy_res ||
          got.load_accepted !== want.load_accepted || got.byte_done !== want.byte_done) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d: pin %0b/%0b busy %0b/%0b taken %0b/%0b done %0b/%0b (exp/got)",
                   n_items - due_results.size() - 1,
                   want.pin_level, got.pin_level, want.busy_res, got.busy_res,
                   want.load_accepted, got.load_accepted, want.byte_done, got.byte_done);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int   stall_left;
  int   idle_cycles;

  pulse_checker pulses = new();

  pwbs_item_if   item_ch();
  pwbs_result_if result_ch();
  pwbs_cfg_if    cfg_ch();

  pulse_width_bit_serializer_core #(
    .BITS_PER_BYTE(BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long ones; none at all in calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result-side backpressure.
  always @(posedge clk) begin
    if (rst) stall_left = 0;
    else if (stall_left > 0) stall_left--;
    else stall_left = pick_gap();
    result_ch.ready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready)
      pulses.take_item(command_t'(item_ch.command), item_ch.data_byte);
    if (!rst && result_ch.valid && result_ch.ready)
      pulses.check_result('{result_ch.pin_level, result_ch.busy_res,
                            result_ch.load_accepted, result_ch.byte_done});
    if (!rst && cfg_ch.valid && cfg_ch.ready)
      pulses.write_timing(cfg_ch.index, cfg_ch.data);
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_item(command_t cmd, logic [7:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.command <= cmd;
    item_ch.data_byte <= d;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Hold off the sender until every outstanding result has been checked.
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pulses.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [TICK_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Call only after settle(); may also poke an unmapped index, which must be ignored.
  task automatic set_timing(logic [15:0] hz, logic [15:0] pz, logic [15:0] ho, logic [15:0] po);
    put_reg(REG_HIGH_ZERO, hz);
    put_reg(REG_PERIOD_ZERO, pz);
    put_reg(REG_HIGH_ONE, ho);
    put_reg(REG_PERIOD_ONE, po);
    if ($urandom_range(0, 1))
      put_reg(CFG_INDEX_W'($urandom_range(4, 255)), TICK_W'($urandom_range(0, 65535)));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] t[4];
    rst = 1'b1;
    calm = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.command = CMD_TICK;
    item_ch.data_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset timing: tick while idle, load while idle, then shrink the running bit.
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_LOAD, 8'h5A);
    send_ticks(2);
    settle();
    // zero bits: no high time and zero length; one bits: period below high time
    set_timing(16'd0, 16'd0, 16'd2, 16'd1);
    send_item(CMD_LOAD, 8'h00);
    send_item(CMD_LOAD, 8'hFF);
    send_ticks(21);
    settle();

    // Extreme timings, cut short by rewriting the registers mid-bit.
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_LOAD, 8'h80);
    send_ticks(3);
    settle();
    set_timing(16'd1, 16'd0, 16'd0, 16'd2);
    send_ticks(16);
    settle();
    set_timing(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    send_item(CMD_LOAD, 8'h01);
    send_ticks(2);
    settle();

    for (int phase = 0; phase < 12; phase++) begin
      calm = (phase % 3 == 0);
      case ($urandom_range(0, 3))
        0: foreach (t[i]) t[i] = 16'($urandom_range(0, 3));
        1: foreach (t[i]) t[i] = 16'($urandom_range(0, 10));
        2: begin
          t[0] = 16'($urandom_range(0, 3));
          t[1] = 16'($urandom_range(0, 3));
          t[2] = 16'($urandom_range(5, 20));
          t[3] = 16'($urandom_range(0, 25));
        end
        default: begin
          t[0] = '0;
          t[1] = 16'($urandom_range(0, 2));
          t[2] = 16'($urandom_range(0, 6));
          t[3] = '0;
        end
      endcase
      set_timing(t[0], t[1], t[2], t[3]);
      for (int n = 0; n < 105; n++) begin
        if ($urandom_range(0, 9) == 0) send_item(CMD_LOAD, 8'($urandom_range(0, 255)));
        else send_item(CMD_TICK, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 149) == 0) settle();
      end
      settle();
    end

    calm = 1'b1;
    repeat (8) @(posedge clk);
    $display("Run covered %0d items: %0d loads taken, %0d refused, %0d bytes sent.",
             pulses.n_items, pulses.n_taken, pulses.n_refused, pulses.n_bytes);
    $display("Timing registers written %0d times, including unmapped indexes and extremes.",
             pulses.n_writes);
    if (pulses.errors == 0 && pulses.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d results outstanding", pulses.errors, pulses.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
